### rtl/erl_pkg.sv
`timescale 1ns / 1ps
package erl_pkg;

	localparam int EXPERT_CNT_DEF = 64;
	localparam int MAX_SLOTS_DEF  = 32;

	localparam int ID_W     = 6;
	localparam int STATUS_W = 3;
	localparam int CAP_W    = 6;
	localparam int DATA_W   = 8;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

	localparam logic CMD_DEMAND = 1'b0;
	localparam logic CMD_TOUCH  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_HIT         = 3'd0,
		ST_MISS_STORED = 3'd1,
		ST_MISS_TEMP   = 3'd2,
		ST_EVICT       = 3'd3,
		ST_MOVED       = 3'd4,
		ST_ABSENT      = 3'd5
	} status_t;

endpackage

### rtl/expert_residency_lru_core.sv
// Sequence: a hit or an absent touch is answered from S_DECODE; a demand miss
//   passes S_DECODE and S_EVICT, with one S_VICTIM visit per eviction; a touch
//   of a resident expert makes one pass over the recency RAM in S_WALK, then
//   answers from S_TAIL.
// Throughput: one item at a time; s_tready returns once the last result is registered.
// Reset: arst_n clears occupancy and residency, capacity returns to 32; the
//   recency RAM is not cleared, only entries below occupancy are read.
`timescale 1ns / 1ps
module expert_residency_lru_core
	import erl_pkg::*;
#(
	parameter int EXPERT_CNT = EXPERT_CNT_DEF,
	parameter int MAX_SLOTS  = MAX_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CAP_W-1:0]  cfg_wdata,   // capacity
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,     // [5:0] expert_id
	input  logic [0:0]        s_tuser,     // [0] cmd
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata      // [2:0] status
);

	localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CW = $clog2(MAX_SLOTS + 1);

	logic [CAP_W-1:0] capacity_q;
	logic [CW-1:0]    cap_eff;
	status_t          status;
	logic             ram_we;
	logic [SW-1:0]    ram_waddr;
	logic [ID_W-1:0]  ram_wdata;
	logic [SW-1:0]    ram_raddr;
	logic [ID_W-1:0]  ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	assign cap_eff = (int'(capacity_q) > MAX_SLOTS) ? CW'(MAX_SLOTS) : CW'(capacity_q);
	assign m_tdata = {{(DATA_W - STATUS_W){1'b0}}, status};

	erl_seq #(
		.EXPERT_CNT(EXPERT_CNT),
		.MAX_SLOTS (MAX_SLOTS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cap_eff   (cap_eff),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tuser[0]),
		.in_id     (s_tdata[ID_W-1:0]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_status(status),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	erl_list_ram #(
		.DEPTH(MAX_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

### rtl/erl_list_ram.sv
`timescale 1ns / 1ps
module erl_list_ram
	import erl_pkg::*;
#(
	parameter int DEPTH = MAX_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [ID_W-1:0]               wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [ID_W-1:0]               rdata
);

	logic [ID_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/erl_seq.sv
`timescale 1ns / 1ps
module erl_seq
	import erl_pkg::*;
#(
	parameter int EXPERT_CNT = EXPERT_CNT_DEF,
	parameter int MAX_SLOTS  = MAX_SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [$clog2(MAX_SLOTS+1)-1:0]    cap_eff,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              in_cmd,
	input  logic [ID_W-1:0]                   in_id,
	output logic                              out_valid,
	input  logic                              out_ready,
	output status_t                           out_status,
	output logic                              ram_we,
	output logic [((MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1)-1:0] ram_waddr,
	output logic [ID_W-1:0]                   ram_wdata,
	output logic [((MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1)-1:0] ram_raddr,
	input  logic [ID_W-1:0]                   ram_rdata
);

	localparam int SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CW  = $clog2(MAX_SLOTS + 1);
	localparam int CW1 = CW + 1;
	localparam int NW  = $clog2(EXPERT_CNT);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_EVICT  = 6'b000100,
		S_VICTIM = 6'b001000,
		S_WALK   = 6'b010000,
		S_TAIL   = 6'b100000
	} state_t;

	state_t                 state_q;
	logic                   cmd_q;
	logic [ID_W-1:0]        id_q;
	logic [SW-1:0]          head_q;
	logic [CW-1:0]          count_q;
	logic [EXPERT_CNT-1:0]  map_q;
	logic [SW-1:0]          walk_q;
	logic                   found_q;
	logic                   out_valid_q;
	status_t                out_status_q;

	logic          can_emit;
	logic          emit;
	logic          in_range;
	logic          resident;
	logic          evict_cond;
	logic          store_ok;
	logic          last;
	logic          match;
	logic [NW-1:0] map_idx;
	logic [NW-1:0] victim_idx;

	// circular slot address: base + offset, wrapped once
	function automatic logic [SW-1:0] phys(input logic [SW-1:0] base,
			input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = CW1'(base) + CW1'(off);
		if (sum >= CW1'(MAX_SLOTS)) begin
			sum = sum - CW1'(MAX_SLOTS);
		end
		return sum[SW-1:0];
	endfunction

	assign can_emit   = !out_valid_q || out_ready;
	assign in_range   = int'(id_q) < EXPERT_CNT;
	assign map_idx    = NW'(id_q);
	assign victim_idx = NW'(ram_rdata);
	assign resident   = map_q[map_idx];
	assign evict_cond = (cap_eff != '0) && (count_q >= cap_eff) && (count_q != '0);
	assign store_ok   = (cap_eff != '0) && (CW1'(count_q) < CW1'(MAX_SLOTS));
	assign last       = (CW1'(walk_q) + CW1'(1)) >= CW1'(count_q);
	assign match      = ram_rdata == id_q;

	assign in_ready   = state_q == S_IDLE;
	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;

	always_comb begin
		emit = 1'b0;
		unique case (state_q)
			S_DECODE: begin
				if (!in_range) begin
					emit = can_emit;
				end else if (cmd_q == CMD_DEMAND) begin
					emit = can_emit && resident;
				end else begin
					emit = can_emit && !resident;
				end
			end
			S_EVICT: begin
				emit = can_emit && !evict_cond;
			end
			S_VICTIM, S_TAIL: begin
				emit = can_emit;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		ram_raddr = head_q;
		ram_we    = 1'b0;
		ram_waddr = head_q;
		ram_wdata = id_q;
		unique case (state_q)
			S_EVICT: begin
				if (!evict_cond && can_emit && store_ok) begin
					ram_we    = 1'b1;
					ram_waddr = phys(head_q, count_q);
				end
			end
			S_WALK: begin
				ram_raddr = phys(head_q, CW'(walk_q) + CW'(1));
				if (found_q) begin
					ram_we    = 1'b1;
					ram_waddr = phys(head_q, CW'(walk_q) - CW'(1));
					ram_wdata = ram_rdata;
				end
			end
			S_TAIL: begin
				if (found_q && can_emit) begin
					ram_we    = 1'b1;
					ram_waddr = phys(head_q, count_q - CW'(1));
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmd_q        <= CMD_DEMAND;
			id_q         <= '0;
			head_q       <= '0;
			count_q      <= '0;
			map_q        <= '0;
			walk_q       <= '0;
			found_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_HIT;
		end else begin
			out_valid_q <= emit || (out_valid_q && !out_ready);
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q   <= in_cmd;
						id_q    <= in_id;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (!in_range) begin
						if (can_emit) begin
							out_status_q <= (cmd_q == CMD_TOUCH) ? ST_ABSENT : ST_MISS_TEMP;
							state_q      <= S_IDLE;
						end
					end else if (cmd_q == CMD_DEMAND) begin
						if (!resident) begin
							state_q <= S_EVICT;
						end else if (can_emit) begin
							out_status_q <= ST_HIT;
							state_q      <= S_IDLE;
						end
					end else begin
						if (resident) begin
							walk_q  <= '0;
							found_q <= 1'b0;
							state_q <= S_WALK;
						end else if (can_emit) begin
							out_status_q <= ST_ABSENT;
							state_q      <= S_IDLE;
						end
					end
				end
				S_EVICT: begin
					if (evict_cond) begin
						state_q <= S_VICTIM;
					end else if (can_emit) begin
						state_q <= S_IDLE;
						if (store_ok) begin
							count_q        <= count_q + CW'(1);
							map_q[map_idx] <= 1'b1;
							out_status_q   <= ST_MISS_STORED;
						end else begin
							out_status_q <= ST_MISS_TEMP;
						end
					end
				end
				S_VICTIM: begin
					if (can_emit) begin
						if (int'(ram_rdata) < EXPERT_CNT) begin
							map_q[victim_idx] <= 1'b0;
						end
						head_q       <= phys(head_q, CW'(1));
						count_q      <= count_q - CW'(1);
						out_status_q <= ST_EVICT;
						state_q      <= S_EVICT;
					end
				end
				S_WALK: begin
					found_q <= found_q | match;
					walk_q  <= walk_q + SW'(1);
					if (last) begin
						state_q <= S_TAIL;
					end
				end
				S_TAIL: begin
					if (can_emit) begin
						out_status_q <= ST_MOVED;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/erl_checker.sv
`timescale 1ns / 1ps
module erl_checker
	import erl_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [DATA_W-1:0] m_tdata
);

	// a stalled result transfer keeps its data
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[STATUS_W-1:0] <= ST_ABSENT)
			&& (m_tdata[DATA_W-1:STATUS_W] == '0))
		else $error("illegal status code");

	// one item in flight: busy right after an input transfer
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready right after input transfer");

endmodule

bind expert_residency_lru_core erl_checker u_chk (.*);

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import erl_pkg::*;

	localparam int HOLD_CYCLES    = 400;
	localparam int IDLE_PCT       = 14;
	localparam int DRAIN_CYCLES   = 80;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASES         = 10;
	localparam int PHASE_ITEMS    = 40;

	// expected status stream for the LRU residency tracker
	class residency_scoreboard;
		status_t          expected_q[$];
		logic [ID_W-1:0]  lru_order[$];
		bit               resident[EXPERT_CNT_DEF];
		logic [CAP_W-1:0] capacity;
		int mismatches, requests, results, evictions, hits, moves;

		function new();
			capacity = CAP_RESET;
		endfunction

		function void set_capacity(logic [CAP_W-1:0] value);
			capacity = value;
		endfunction

		function void expect_status(status_t s);
			expected_q.insert(expected_q.size(), s);
		endfunction

		function void note_request(logic cmd, logic [ID_W-1:0] id);
			int limit;
			logic [ID_W-1:0] victim;
			limit = (capacity > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : int'(capacity);
			requests++;
			if (cmd == CMD_DEMAND) begin
				if (resident[id]) begin
					expect_status(ST_HIT);
				end else begin
					// a lowered capacity can evict several entries at once
					while (limit > 0 && lru_order.size() >= limit) begin
						victim = lru_order[0];
						lru_order.delete(0);
						resident[victim] = 1'b0;
						expect_status(ST_EVICT);
					end
					if (limit == 0 || lru_order.size() >= MAX_SLOTS_DEF) begin
						expect_status(ST_MISS_TEMP);
					end else begin
						lru_order.insert(lru_order.size(), id);
						resident[id] = 1'b1;
						expect_status(ST_MISS_STORED);
					end
				end
			end else if (resident[id]) begin
				foreach (lru_order[i]) begin
					if (lru_order[i] == id) begin
						lru_order.delete(i);
						break;
					end
				end
				lru_order.insert(lru_order.size(), id);
				expect_status(ST_MOVED);
			end else begin
				expect_status(ST_ABSENT);
			end
		endfunction

		function void check_status(logic [DATA_W-1:0] data);
			status_t got, want;
			got = status_t'(data[STATUS_W-1:0]);
			results++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result, status %0d", $realtime, got);
				return;
			end
			want = expected_q[0];
			expected_q.delete(0);
			if (got != want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: status mismatch: expected %0d (%s), got %0d (%s)",
						$realtime, want, want.name(), got, got.name());
			end else begin
				if (got == ST_EVICT) evictions++;
				if (got == ST_HIT) hits++;
				if (got == ST_MOVED) moves++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CAP_W-1:0]  cfg_wdata;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;   // [5:0] expert_id
	logic [0:0]        s_tuser;   // [0] cmd
	logic              m_tvalid;
	logic              m_tready;
	logic [DATA_W-1:0] m_tdata;   // [2:0] status

	residency_scoreboard sb;
	bit quiet;
	bit hold_req;
	int settings;
	int stall_cycles;

	expert_residency_lru_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// receiver: random backpressure, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (quiet)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_status(m_tdata);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $realtime, stall_cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_item(input logic cmd, input logic [ID_W-1:0] id);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= DATA_W'(id);
		s_tuser  <= cmd;
		do @(posedge clk); while (!s_tready);
		sb.note_request(cmd, id);
	endtask

	// only while idle: every pending result drained, then a settle pause
	task automatic write_capacity(input logic [CAP_W-1:0] value);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_capacity(value);
		settings++;
	endtask

	task automatic run_phase(input logic [CAP_W-1:0] cap, input bit stall, input bit calm);
		int span, base, id;
		logic cmd;
		write_capacity(cap);
		quiet = calm;
		if (stall) hold_req = 1'b1;
		span = ((cap > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : int'(cap)) + 4;
		base = $urandom_range(EXPERT_CNT_DEF - 1);
		repeat (PHASE_ITEMS) begin
			cmd = ($urandom_range(99) < 30) ? CMD_TOUCH : CMD_DEMAND;
			if ($urandom_range(99) < 15)
				id = $urandom_range(EXPERT_CNT_DEF - 1);
			else
				id = (base + $urandom_range(span - 1)) % EXPERT_CNT_DEF;
			send_item(cmd, ID_W'(id));
		end
		quiet = 1'b0;
	endtask

	logic [CAP_W-1:0] phase_caps [PHASES] = '{6'd6, 6'd0, 6'd63, 6'd2, 6'd32,
		6'd17, 6'd1, 6'd40, 6'd9, 6'd32};

	initial begin
		sb           = new();
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		quiet        = 1'b0;
		hold_req     = 1'b0;
		settings     = 0;
		stall_cycles = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		write_capacity(6'd32);
		send_item(CMD_DEMAND, 6'd0);
		send_item(CMD_DEMAND, 6'd63);
		send_item(CMD_DEMAND, 6'd0);
		send_item(CMD_TOUCH, 6'd0);
		send_item(CMD_TOUCH, 6'd5);
		send_item(CMD_TOUCH, 6'd63);
		send_item(CMD_DEMAND, 6'd63);
		send_item(CMD_DEMAND, 6'd42);
		send_item(CMD_TOUCH, 6'd42);

		// capacity lowered below occupancy
		write_capacity(6'd1);
		send_item(CMD_DEMAND, 6'd21);
		send_item(CMD_DEMAND, 6'd21);
		send_item(CMD_DEMAND, 6'd22);

		// zero capacity with a resident left over
		write_capacity(6'd0);
		send_item(CMD_DEMAND, 6'd22);
		send_item(CMD_TOUCH, 6'd22);
		send_item(CMD_DEMAND, 6'd7);
		send_item(CMD_TOUCH, 6'd7);

		// capacity above the slot count: fill the list and run past it
		write_capacity(6'd63);
		for (int e = 24; e <= 56; e++)
			send_item(CMD_DEMAND, ID_W'(e));
		send_item(CMD_TOUCH, 6'd25);
		send_item(CMD_TOUCH, 6'd56);

		// full list down to one slot: the longest eviction burst
		write_capacity(6'd1);
		send_item(CMD_DEMAND, 6'd3);

		for (int p = 0; p < PHASES; p++)
			run_phase(phase_caps[p], p == 2, p == 4);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d requests over %0d capacity settings, %0d results checked",
			sb.requests, settings, sb.results);
		$display("Saw %0d hits, %0d evictions, %0d touch moves, %0d mismatches",
			sb.hits, sb.evictions, sb.moves, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

### sim.f
rtl/erl_pkg.sv
rtl/erl_list_ram.sv
rtl/erl_seq.sv
rtl/expert_residency_lru_core.sv
rtl/erl_checker.sv
tb/testbench.sv
